>>> rtl/core/single_to_ue4m3_quantize_assert.svh
// Assertion macros shared by the RTL.
`ifndef SINGLE_TO_UE4M3_QUANTIZE_ASSERT_SVH
`define SINGLE_TO_UE4M3_QUANTIZE_ASSERT_SVH

// Checked only while out of reset.
`define SQU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SQU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/squ_pkg.sv
package squ_pkg;

    localparam int unsigned VAL_W  = 32;
    localparam int unsigned CODE_W = 7;
    localparam int unsigned Y_W    = 30;  // scaled below-normal value, units of 2^-26
    localparam int unsigned YR_W   = 31;  // rounded value, room for the carry

    localparam logic [7:0]        EXP_ALL_ONES = 8'hFF;
    localparam logic [7:0]        EXP_TINY_MAX = 8'd114;  // at or below this: code 0
    localparam logic [7:0]        EXP_SUB_MAX  = 8'd120;
    localparam logic [7:0]        EXP_SAT_MIN  = 8'd135;
    localparam logic [7:0]        EXP_SUB_BASE = 8'd115;
    localparam logic [7:0]        EXP_BIAS_ADJ = 8'd120;
    localparam logic [3:0]        EXP_TOP      = 4'd14;
    localparam logic [CODE_W-1:0] CODE_SAT     = 7'h7E;
    localparam logic [CODE_W-1:0] CODE_ZERO    = 7'h00;
    localparam logic [4:0]        SUB_MAN_MAX  = 5'd7;
    localparam logic [Y_W-1:0]    Y_HALF       = 30'h0200_0000;  // 0.5 scaled by 2^26

    typedef struct packed {
        logic              sub;   // below-normal path
        logic [CODE_W-1:0] code;  // final code when not below-normal
        logic [Y_W-1:0]    y;
    } t_s1;

    typedef struct packed {
        logic              sub;
        logic [CODE_W-1:0] code;
        logic [YR_W-1:0]   yr;
    } t_s2;

endpackage

>>> rtl/core/squ_if.sv
interface squ_in_if;
    logic                          valid;
    logic                          ready;
    logic [squ_pkg::VAL_W-1:0]     value_bits;
    modport source  (output valid, output value_bits, input ready);
    modport sink    (input valid, input value_bits, output ready);
    modport monitor (input valid, input value_bits, input ready);
endinterface

interface squ_out_if;
    logic                          valid;
    logic                          ready;
    logic [squ_pkg::CODE_W-1:0]    code;
    modport source  (output valid, output code, input ready);
    modport sink    (input valid, input code, output ready);
    modport monitor (input valid, input code, input ready);
endinterface

>>> rtl/core/squ_decode.sv
// Stage 1: classify, normal-path code, scaled below-normal value.
module squ_decode (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [squ_pkg::VAL_W-1:0]  i_bits,
    output logic                       o_ready,
    output logic                       o_valid,
    output squ_pkg::t_s1               o_data,
    input  logic                       i_ready
);
    logic          r_valid;
    squ_pkg::t_s1  r_data;
    squ_pkg::t_s1  n_data;
    logic          adv;

    assign adv     = !r_valid || i_ready;
    assign o_ready = adv;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        logic [7:0]  e;
        logic [22:0] f;
        logic [3:0]  ex;
        logic [3:0]  man;
        logic [7:0]  sh;
        e   = i_bits[30:23];
        f   = i_bits[22:0];
        ex  = 4'(e - squ_pkg::EXP_BIAS_ADJ);
        man = {1'b0, f[22:20]} + {3'b000, f[19]};
        sh  = e - squ_pkg::EXP_SUB_BASE;
        n_data.sub  = 1'b0;
        n_data.code = squ_pkg::CODE_ZERO;
        n_data.y    = (squ_pkg::Y_W'({1'b1, f}) << sh[2:0]) + squ_pkg::Y_HALF;
        if (i_bits[31]) begin
            n_data.code = squ_pkg::CODE_ZERO;
        end else if (e == squ_pkg::EXP_ALL_ONES) begin
            n_data.code = (f != 23'd0) ? squ_pkg::CODE_ZERO : squ_pkg::CODE_SAT;
        end else if (e <= squ_pkg::EXP_TINY_MAX) begin
            n_data.code = squ_pkg::CODE_ZERO;
        end else if (e <= squ_pkg::EXP_SUB_MAX) begin
            n_data.sub = 1'b1;
        end else if (e >= squ_pkg::EXP_SAT_MIN) begin
            n_data.code = squ_pkg::CODE_SAT;
        end else if (man[3]) begin
            n_data.code = (ex == squ_pkg::EXP_TOP) ? squ_pkg::CODE_SAT
                                                   : {ex + 4'd1, 3'b000};
        end else begin
            n_data.code = {ex, man[2:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_data <= n_data;
        end
    end
endmodule

>>> rtl/core/squ_round.sv
// Stage 2: round the scaled value to 24 significant bits, ties to even.
module squ_round (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  squ_pkg::t_s1  i_data,
    output logic          o_ready,
    output logic          o_valid,
    output squ_pkg::t_s2  o_data,
    input  logic          i_ready
);
    logic          r_valid;
    squ_pkg::t_s2  r_data;
    squ_pkg::t_s2  n_data;
    logic          adv;

    assign adv     = !r_valid || i_ready;
    assign o_ready = adv;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        logic [2:0]              d;
        logic [squ_pkg::Y_W-1:0] y;
        logic [squ_pkg::Y_W-1:0] q;
        logic [squ_pkg::Y_W-1:0] rem;
        logic [squ_pkg::Y_W-1:0] half;
        logic                    up;
        y = i_data.y;
        // y >= 2^25 always, so the drop count is 2..6
        if (y[29])      d = 3'd6;
        else if (y[28]) d = 3'd5;
        else if (y[27]) d = 3'd4;
        else if (y[26]) d = 3'd3;
        else            d = 3'd2;
        half = squ_pkg::Y_W'(1) << (d - 3'd1);
        rem  = y & ((squ_pkg::Y_W'(1) << d) - squ_pkg::Y_W'(1));
        q    = y >> d;
        up   = (rem > half) || ((rem == half) && q[0]);
        n_data.sub  = i_data.sub;
        n_data.code = i_data.code;
        n_data.yr   = (squ_pkg::YR_W'(q) + squ_pkg::YR_W'(up)) << d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_data <= n_data;
        end
    end
endmodule

>>> rtl/core/squ_pack.sv
// Stage 3: integer part of the rounded value, limited to 7, for below-normal words; output register.
module squ_pack (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  squ_pkg::t_s2                i_data,
    output logic                        o_ready,
    output logic                        o_valid,
    output logic [squ_pkg::CODE_W-1:0]  o_code,
    input  logic                        i_ready
);
    logic                        r_valid;
    logic [squ_pkg::CODE_W-1:0]  r_code;
    logic [squ_pkg::CODE_W-1:0]  n_code;
    logic                        adv;
    logic [4:0]                  ip;

    assign adv     = !r_valid || i_ready;
    assign o_ready = adv;
    assign o_valid = r_valid;
    assign o_code  = r_code;
    assign ip      = i_data.yr[30:26];

    always_comb begin
        if (!i_data.sub) begin
            n_code = i_data.code;
        end else if (ip > squ_pkg::SUB_MAN_MAX) begin
            n_code = squ_pkg::CODE_W'(squ_pkg::SUB_MAN_MAX);
        end else begin
            n_code = squ_pkg::CODE_W'(ip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_code <= n_code;
        end
    end
endmodule

>>> rtl/core/single_to_ue4m3_quantize.sv
// FP32 to unsigned E4M3 (bias 7) converter. One word is taken every cycle while
// any stage has room. A word passes through the decode, round and pack stages,
// each a register with its own valid bit. The stages move independently, so a
// stall on the output only fills the bubbles ahead of it and the input keeps
// taking words while any stage has room. Negative, zero, NaN and tiny inputs
// give 0; 256 and above, infinity included, give 0x7E. Normal results round
// half up on input mantissa bit 19; below-normal results round the value
// x*512 + 0.5 to 24 significant bits, ties to even, and take its integer part,
// capped at 7.
`include "single_to_ue4m3_quantize_assert.svh"

module single_to_ue4m3_quantize (
    input  logic        i_clk,
    input  logic        i_rst_n,
    squ_in_if.sink      i_in,
    squ_out_if.source   o_out
);
    // stage 1 -> 2
    logic          s1_valid;
    logic          s1_ready;
    squ_pkg::t_s1  s1_data;
    // stage 2 -> 3
    logic          s2_valid;
    logic          s2_ready;
    squ_pkg::t_s2  s2_data;

    squ_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_bits  (i_in.value_bits),
        .o_ready (i_in.ready),
        .o_valid (s1_valid),
        .o_data  (s1_data),
        .i_ready (s1_ready)
    );

    squ_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .o_ready (s1_ready),
        .o_valid (s2_valid),
        .o_data  (s2_data),
        .i_ready (s2_ready)
    );

    squ_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_data  (s2_data),
        .o_ready (s2_ready),
        .o_valid (o_out.valid),
        .o_code  (o_out.code),
        .i_ready (o_out.ready)
    );

    // codes above the saturation value never leave the block
    `SQU_ASSERT(a_code_range, i_clk, i_rst_n, o_out.valid |-> (o_out.code <= squ_pkg::CODE_SAT), "code above saturation")
    // pipeline comes out of reset empty
    `SQU_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out.valid && !s1_valid && !s2_valid, "valid after reset")
    // a full, stalled pipeline refuses new words
    `SQU_ASSERT(a_full_stall, i_clk, i_rst_n, (s1_valid && s2_valid && o_out.valid && !o_out.ready) |-> !i_in.ready, "word taken into full pipeline")
endmodule

>>> tb/squ_tb_pkg.sv
`timescale 1ns / 1ps
package squ_tb_pkg;
    import squ_pkg::*;

    // Expected code for one FP32 word.
    function automatic logic [CODE_W-1:0] fp32_to_code(logic [31:0] bits);
        logic [7:0]  bexp;
        logic [22:0] frac;
        logic [31:0] mant;
        logic [31:0] y;
        logic [31:0] q;
        logic [31:0] rem;
        logic [31:0] half;
        int unsigned len;
        int unsigned d;
        logic [4:0]  ex;
        logic [3:0]  man;
        bexp = bits[30:23];
        frac = bits[22:0];
        if (bits[31]) return CODE_ZERO;
        if (bexp == EXP_ALL_ONES) return (frac != 0) ? CODE_ZERO : CODE_SAT;
        if (bexp == 8'd0 && frac == 0) return CODE_ZERO;
        if (bexp <= EXP_SUB_MAX) begin
            if (bexp < EXP_SUB_BASE) return CODE_ZERO;
            mant = {9'd0, 1'b1, frac};
            y = (mant << (bexp - EXP_SUB_BASE)) + 32'h0200_0000;
            len = 0;
            for (int i = 0; i < 32; i++) if (y[i]) len = i + 1;
            if (len > 24) begin
                d = len - 24;
                half = 32'd1 << (d - 1);
                rem = y & ((32'd1 << d) - 1);
                q = y >> d;
                if (rem > half || (rem == half && q[0])) q = q + 1;
                y = q << d;
            end
            q = y >> 26;
            if (q > 7) q = 7;
            return q[CODE_W-1:0];
        end
        if (bexp >= EXP_SAT_MIN) return CODE_SAT;
        ex = 5'(bexp - EXP_BIAS_ADJ);
        man = {1'b0, frac[22:20]} + frac[19];
        if (man > 7) begin
            man = 0;
            ex = ex + 1;
            if (ex >= 15) return CODE_SAT;
        end
        return {ex[3:0], man[2:0]};
    endfunction
endpackage

>>> tb/squ_checker.sv
`timescale 1ns / 1ps
module squ_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    squ_in_if.monitor   i_in_mon,
    squ_out_if.monitor  i_out_mon,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);
    import squ_pkg::*;
    import squ_tb_pkg::*;

    logic [CODE_W-1:0] code_q[$];
    logic [31:0]       word_q[$];

    initial begin
        o_errors = 0;
        o_results = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                code_q.push_back(fp32_to_code(i_in_mon.value_bits));
                word_q.push_back(i_in_mon.value_bits);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                o_results = o_results + 1;
                if (code_q.size() == 0) begin
                    o_errors = o_errors + 1;
                    if (o_errors <= 10)
                        $display("mismatch: unexpected code %h", i_out_mon.code);
                end else begin
                    if (code_q[0] !== i_out_mon.code) begin
                        o_errors = o_errors + 1;
                        if (o_errors <= 10)
                            $display("mismatch: word %h exp %h got %h",
                                     word_q[0], code_q[0], i_out_mon.code);
                    end
                    void'(code_q.pop_front());
                    void'(word_q.pop_front());
                end
            end
            o_pending = code_q.size();
        end
    end
endmodule

>>> tb/single_to_ue4m3_quantize_tb.sv
`timescale 1ns / 1ps
module single_to_ue4m3_quantize_tb;
    import squ_pkg::*;

    localparam int WATCHDOG = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors;
    int   pending;
    int   results;
    int   sent = 0;
    int   idle_cnt = 0;
    int   src_idle = 38;   // per cent of cycles the sender holds off
    int   snk_idle = 72;   // per cent of cycles the receiver stalls

    squ_in_if  in_if ();
    squ_out_if out_if ();

    always #1 i_clk = ~i_clk;

    single_to_ue4m3_quantize DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    squ_checker u_chk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_mon (in_if.monitor),
        .i_out_mon(out_if.monitor),
        .o_errors (errors),
        .o_pending(pending),
        .o_results(results)
    );

    initial begin
        in_if.valid = 1'b0;
        in_if.value_bits = '0;
        out_if.ready = 1'b0;
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_idle);
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG) begin
            $display("watchdog expired");
            $display("TB_ERROR");
            $finish;
        end
    end

    // random word, biased towards the interesting exponents
    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(9))
            0, 1, 2: w[30:23] = 8'($urandom_range(113, 136));
            3, 4:    w[30:23] = 8'($urandom_range(121, 134));
            5:       w[30:23] = $urandom_range(1) ? EXP_ALL_ONES : 8'd0;
            6:       w[22:0] = {3'($urandom), $urandom_range(1) ? 20'hFFFFF : 20'h80000};
            default: ;
        endcase
        if ($urandom_range(3) != 0) w[31] = 1'b0;
        return w;
    endfunction

    // one word, with random gaps ahead of it; valid stays up when there is no gap
    task automatic send_word(input logic [31:0] w);
        while ($urandom_range(99) < src_idle) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value_bits <= w;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    logic [31:0] directed[] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
        32'h7FC0_0000, 32'h7F80_0001, 32'h43E0_0000, 32'h4380_0000,
        32'h43DF_FFFF, 32'h3C80_0000, 32'h3C7F_FFFF, 32'h3C88_0000,
        32'h3CFF_FFFF, 32'h3F80_0000, 32'h3F88_0000, 32'h3FF8_0000,
        32'h3B00_0000, 32'h3A80_0000, 32'h3980_0000, 32'h3900_0000,
        32'h0000_0001, 32'h007F_FFFF, 32'h7F7F_FFFF, 32'hFFFF_FFFF,
        32'h3B7F_FFFF
    };

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zeros, signs, NaN, infinity, saturation, rounding carry,
        // the normal/below-normal boundary and tiny values
        foreach (directed[i]) send_word(directed[i]);
        // hold off until every expected code has come back
        drain();

        for (int i = 0; i < 220; i++) send_word(rand_word());
        drain();
        src_idle = 72;
        snk_idle = 38;
        for (int i = 0; i < 220; i++) send_word(rand_word());
        drain();
        src_idle = 0;
        snk_idle = 0;
        for (int i = 0; i < 210; i++) send_word(rand_word());
        drain();

        $display("%0d words sent, %0d codes checked over three idling phases",
                 sent, results);
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
